### src/c6502_pkg.sv
`timescale 1ns / 1ps

package c6502_pkg;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,  OP_BCS = 6'd4,
    OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,  OP_BNE = 6'd8,  OP_BPL = 6'd9,
    OP_BRK = 6'd10, OP_BVC = 6'd11, OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14,
    OP_CLI = 6'd15, OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
    OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23, OP_INC = 6'd24,
    OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27, OP_JSR = 6'd28, OP_LDA = 6'd29,
    OP_LDX = 6'd30, OP_LDY = 6'd31, OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34,
    OP_PHA = 6'd35, OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
    OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43, OP_SEC = 6'd44,
    OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47, OP_STX = 6'd48, OP_STY = 6'd49,
    OP_TAX = 6'd50, OP_TAY = 6'd51, OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54,
    OP_TYA = 6'd55
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_PUSH,
    ST_PULL
  } seq_state_t;

  localparam logic CFG_IRQ_VECTOR = 1'b0;
  localparam logic CFG_START_PC   = 1'b1;

  localparam logic [7:0]  SP_RESET  = 8'hFD;
  localparam logic [15:0] BRK_VEC   = 16'hFFFE;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  typedef struct packed {
    logic n;
    logic v;
    logic b;
    logic d;
    logic i;
    logic z;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  operand;
    logic [15:0] address;
    logic        to_memory;
    logic [1:0]  length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_ptr;
    logic [15:0] prog_counter;
    logic [7:0]  status;
    logic        mem_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
  } out_item_t;

  function automatic logic [7:0] pack_status(flags_t f, logic brk_bit);
    pack_status = {f.n, f.v, 1'b1, f.b | brk_bit, f.d, f.i, f.z, f.c};
  endfunction

  function automatic flags_t unpack_status(logic [7:0] s);
    unpack_status = '{n: s[7], v: s[6], b: s[4], d: s[3], i: s[2], z: s[1], c: s[0]};
  endfunction

endpackage

### src/cpu_6502_execute_unit.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_stall   | in_item_t (kind, operand, address, ...)
// out_    | output    | out_valid / out_stall | out_item_t (registers, status, write)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (irq_vector, start_pc)
//
// Most items finish when taken; PHA and PHP push their byte then, while JSR and BRK push
// their later bytes in ST_PUSH and PLA, PLP, RTS and RTI pull their bytes in ST_PULL:
// the single-port stack memory moves one byte per cycle and its read data is registered.
// Reset clears A, X, Y and all control, sets SP to 0xFD and I; the first item takes start_pc.
// A stalled output holds its item; in ST_RUN a new item is taken once the output slot frees.
// The stack memory is not cleared after reset.

module cpu_6502_execute_unit
  import c6502_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0] stack_mem [STACK_DEPTH];

  logic [15:0] irq_vec_r, start_pc_r;
  logic [7:0]  a_r, x_r, y_r, sp_r;
  logic [15:0] pc_r;
  flags_t      fl_r;
  logic        first_r;
  seq_state_t  st_r, st_nxt;

  logic        out_valid_r;
  out_item_t   out_data_r;

  logic [1:0]    push_left_r;
  logic [AW-1:0] push_idx_r;
  logic [7:0]    push_d0_r, push_d1_r;

  op_t           pull_op_r;
  logic [1:0]    pull_n_r, pull_cnt_r;
  logic [AW-1:0] pull_idx_r;
  logic [7:0]    pb0_r, pb1_r;
  logic [7:0]    rd_r;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_idx;
  logic [7:0]    mem_wd;

  logic        out_free, accept, pull_last, pull_fin;
  logic [7:0]  a_n, x_n, y_n, sp_n;
  logic [15:0] pc_n, pc_b, w16;
  flags_t      fl_n;
  logic        wr;
  logic [7:0]  wdata, v, m2;
  logic [8:0]  sum9;
  logic        br, is_pull, is_push_more;
  logic [1:0]  push_more, pull_n;
  logic [7:0]  pd0, pd1;
  op_t         op;
  logic [7:0]  pl_a;
  logic [15:0] pl_pc;
  flags_t      pl_fl;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (st_r != ST_RUN) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pull_last = (pull_cnt_r + 2'd1) == pull_n_r;
  assign pull_fin  = (st_r == ST_PULL) && pull_last && out_free;

  always_comb begin
    op = op_t'(in_data.kind);
    a_n = a_r; x_n = x_r; y_n = y_r; sp_n = sp_r; fl_n = fl_r;
    pc_b = (first_r ? start_pc_r : pc_r) + {14'd0, in_data.length};
    pc_n = pc_b;
    wr = 1'b0; wdata = 8'd0; br = 1'b0;
    is_pull = 1'b0; pull_n = 2'd1; is_push_more = 1'b0; push_more = 2'd0;
    pd0 = 8'd0; pd1 = 8'd0;
    m2 = (op == OP_SBC) ? ~in_data.operand : in_data.operand;
    sum9 = {1'b0, a_r} + {1'b0, m2} + {8'd0, fl_r.c};
    v = in_data.to_memory ? in_data.operand : a_r;
    w16 = pc_b;
    mem_we = 1'b0; mem_re = 1'b0; mem_idx = sp_r[AW-1:0]; mem_wd = 8'd0;
    unique case (op)
      OP_ADC, OP_SBC: begin
        a_n = sum9[7:0];
        fl_n.c = sum9[8];
        fl_n.v = (a_r[7] ^ sum9[7]) & (m2[7] ^ sum9[7]);
      end
      OP_AND: a_n = a_r & in_data.operand;
      OP_ORA: a_n = a_r | in_data.operand;
      OP_EOR: a_n = a_r ^ in_data.operand;
      OP_ASL: begin fl_n.c = v[7]; v = {v[6:0], 1'b0}; end
      OP_LSR: begin fl_n.c = v[0]; v = {1'b0, v[7:1]}; end
      OP_ROL: begin fl_n.c = v[7]; v = {v[6:0], fl_r.c}; end
      OP_ROR: begin fl_n.c = v[0]; v = {fl_r.c, v[7:1]}; end
      OP_BCC: br = !fl_r.c;
      OP_BCS: br = fl_r.c;
      OP_BEQ: br = fl_r.z;
      OP_BNE: br = !fl_r.z;
      OP_BMI: br = fl_r.n;
      OP_BPL: br = !fl_r.n;
      OP_BVC: br = !fl_r.v;
      OP_BVS: br = fl_r.v;
      OP_BIT: begin
        fl_n.z = (a_r & in_data.operand) == 8'd0;
        fl_n.v = in_data.operand[6];
        fl_n.n = in_data.operand[7];
      end
      OP_BRK: begin
        w16 = pc_b + 16'd1;
        mem_we = 1'b1; mem_wd = w16[15:8];
        is_push_more = 1'b1; push_more = 2'd2;
        pd0 = w16[7:0]; pd1 = pack_status(fl_r, 1'b1);
        sp_n = sp_r - 8'd3;
        fl_n.b = 1'b1; fl_n.i = 1'b1;
        pc_n = irq_vec_r;
      end
      OP_CLC: fl_n.c = 1'b0;
      OP_CLD: fl_n.d = 1'b0;
      OP_CLI: fl_n.i = 1'b0;
      OP_CLV: fl_n.v = 1'b0;
      OP_SEC: fl_n.c = 1'b1;
      OP_SED: fl_n.d = 1'b1;
      OP_SEI: fl_n.i = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        v = (op == OP_CMP) ? a_r : ((op == OP_CPX) ? x_r : y_r);
        fl_n.c = v >= in_data.operand;
        v = v - in_data.operand;
      end
      OP_DEC: begin v = in_data.operand - 8'd1; wr = 1'b1; wdata = v; end
      OP_INC: begin v = in_data.operand + 8'd1; wr = 1'b1; wdata = v; end
      OP_DEX: x_n = x_r - 8'd1;
      OP_DEY: y_n = y_r - 8'd1;
      OP_INX: x_n = x_r + 8'd1;
      OP_INY: y_n = y_r + 8'd1;
      OP_JMP: pc_n = in_data.address;
      OP_JSR: begin
        w16 = pc_b - 16'd1;
        mem_we = 1'b1; mem_wd = w16[15:8];
        is_push_more = 1'b1; push_more = 2'd1; pd0 = w16[7:0];
        sp_n = sp_r - 8'd2;
        pc_n = in_data.address;
      end
      OP_LDA: a_n = in_data.operand;
      OP_LDX: x_n = in_data.operand;
      OP_LDY: y_n = in_data.operand;
      OP_PHA: begin mem_we = 1'b1; mem_wd = a_r; sp_n = sp_r - 8'd1; end
      OP_PHP: begin
        mem_we = 1'b1; mem_wd = pack_status(fl_r, 1'b1); sp_n = sp_r - 8'd1;
      end
      OP_PLA, OP_PLP: begin is_pull = 1'b1; pull_n = 2'd1; end
      OP_RTS: begin is_pull = 1'b1; pull_n = 2'd2; end
      OP_RTI: begin is_pull = 1'b1; pull_n = 2'd3; end
      OP_STA: begin wr = 1'b1; wdata = a_r; end
      OP_STX: begin wr = 1'b1; wdata = x_r; end
      OP_STY: begin wr = 1'b1; wdata = y_r; end
      OP_TAX: x_n = a_r;
      OP_TAY: y_n = a_r;
      OP_TSX: x_n = sp_r;
      OP_TXA: a_n = x_r;
      OP_TXS: sp_n = x_r;
      OP_TYA: a_n = y_r;
      default: ;
    endcase
    case (op)
      OP_ADC, OP_SBC, OP_AND, OP_ORA, OP_EOR, OP_LDA, OP_TXA, OP_TYA: begin
        fl_n.z = a_n == 8'd0; fl_n.n = a_n[7];
      end
      OP_LDX, OP_DEX, OP_INX, OP_TAX, OP_TSX: begin
        fl_n.z = x_n == 8'd0; fl_n.n = x_n[7];
      end
      OP_LDY, OP_DEY, OP_INY, OP_TAY: begin
        fl_n.z = y_n == 8'd0; fl_n.n = y_n[7];
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_CMP, OP_CPX, OP_CPY, OP_DEC, OP_INC: begin
        fl_n.z = v == 8'd0; fl_n.n = v[7];
      end
      default: ;
    endcase
    if (op == OP_ASL || op == OP_LSR || op == OP_ROL || op == OP_ROR) begin
      if (in_data.to_memory) begin
        wr = 1'b1; wdata = v;
      end else begin
        a_n = v;
      end
    end
    if (br) begin
      pc_n = pc_b + {{8{in_data.operand[7]}}, in_data.operand};
    end
    if (wr && in_data.address[15:8] == STACK_PAGE) begin
      mem_we = 1'b1; mem_idx = in_data.address[AW-1:0]; mem_wd = wdata;
    end
    if (is_pull) begin
      mem_re = 1'b1; mem_idx = AW'(sp_r + 8'd1);
    end
    if (!accept) begin
      mem_we = 1'b0; mem_re = 1'b0;
    end
    if (st_r == ST_PUSH) begin
      mem_we = 1'b1; mem_idx = push_idx_r; mem_wd = push_d0_r;
    end else if (st_r == ST_PULL && !pull_last) begin
      mem_re = 1'b1; mem_idx = pull_idx_r;
    end
  end

  always_comb begin
    pl_a = a_r; pl_fl = fl_r; pl_pc = pc_r;
    case (pull_op_r)
      OP_PLA: begin
        pl_a = rd_r; pl_fl.z = rd_r == 8'd0; pl_fl.n = rd_r[7];
      end
      OP_PLP: pl_fl = unpack_status(rd_r);
      OP_RTS: pl_pc = {rd_r, pb0_r} + 16'd1;
      default: begin
        pl_fl = unpack_status(pb0_r);
        pl_pc = {rd_r, pb1_r};
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_RUN: begin
        if (accept && is_push_more) st_nxt = ST_PUSH;
        else if (accept && is_pull) st_nxt = ST_PULL;
      end
      ST_PUSH: if (push_left_r == 2'd1) st_nxt = ST_RUN;
      ST_PULL: if (pull_fin) st_nxt = ST_RUN;
      default: st_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_idx] <= mem_wd;
    if (mem_re) rd_r <= stack_mem[mem_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RUN;
      irq_vec_r <= 16'd0; start_pc_r <= 16'd0;
      a_r <= 8'd0; x_r <= 8'd0; y_r <= 8'd0; sp_r <= SP_RESET;
      pc_r <= 16'd0; fl_r <= '{i: 1'b1, default: 1'b0};
      first_r <= 1'b1; out_valid_r <= 1'b0;
      push_left_r <= 2'd0; pull_cnt_r <= 2'd0; pull_n_r <= 2'd1;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IRQ_VECTOR) irq_vec_r <= cfg_data;
        else start_pc_r <= cfg_data;
      end
      if ((accept && !is_pull) || pull_fin) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        first_r <= 1'b0;
        pc_r <= pc_n;
        if (is_pull) begin
          pull_op_r <= op; pull_n_r <= pull_n; pull_cnt_r <= 2'd0;
          pull_idx_r <= AW'(sp_r + 8'd2);
        end else begin
          a_r <= a_n; x_r <= x_n; y_r <= y_n; sp_r <= sp_n; fl_r <= fl_n;
          out_data_r <= '{acc: a_n, index_x: x_n, index_y: y_n, stack_ptr: sp_n,
                          prog_counter: pc_n, status: pack_status(fl_n, 1'b0),
                          mem_write: wr, write_address: wr ? in_data.address : 16'd0,
                          write_data: wdata};
          push_left_r <= push_more;
          push_idx_r <= AW'(sp_r - 8'd1);
          push_d0_r <= pd0; push_d1_r <= pd1;
        end
      end
      if (st_r == ST_PUSH) begin
        push_left_r <= push_left_r - 2'd1;
        push_idx_r <= push_idx_r - AW'(1);
        push_d0_r <= push_d1_r;
      end
      if (st_r == ST_PULL && !pull_last) begin
        pull_cnt_r <= pull_cnt_r + 2'd1;
        pull_idx_r <= pull_idx_r + AW'(1);
        if (pull_cnt_r == 2'd0) pb0_r <= rd_r;
        else pb1_r <= rd_r;
      end
      if (pull_fin) begin
        a_r <= pl_a; fl_r <= pl_fl; pc_r <= pl_pc;
        sp_r <= sp_r + {6'd0, pull_n_r};
        out_data_r <= '{acc: pl_a, index_x: x_r, index_y: y_r,
                        stack_ptr: sp_r + {6'd0, pull_n_r}, prog_counter: pl_pc,
                        status: pack_status(pl_fl, 1'b0), mem_write: 1'b0,
                        write_address: 16'd0, write_data: 8'd0};
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) (st_r != ST_RUN) |-> in_stall)
    else $error("Item taken while the stack sequencer is busy.");
  assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
    else $error("Stack memory read and written in one cycle.");
  assert property (@(posedge clk) disable iff (!rst_n) pull_fin |=> out_valid_r)
    else $error("Finished pull did not present an item.");
  assert property (@(posedge clk) disable iff (!rst_n)
      (st_r == ST_PUSH) |-> (push_left_r != 2'd0))
    else $error("Push sequence with nothing left to write.");

endmodule

### tb/sv/cpu_6502_execute_checker.sv
`timescale 1ns / 1ps

module cpu_6502_execute_checker
  import c6502_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [15:0] cfg_data,
  output int        fail_count,
  output int        pending
);

  localparam logic [7:0] F_C = 8'h01;
  localparam logic [7:0] F_Z = 8'h02;
  localparam logic [7:0] F_I = 8'h04;
  localparam logic [7:0] F_D = 8'h08;
  localparam logic [7:0] F_B = 8'h10;
  localparam logic [7:0] F_ONE = 8'h20;
  localparam logic [7:0] F_V = 8'h40;
  localparam logic [7:0] F_N = 8'h80;

  logic [15:0] irq_vec, boot_pc;
  logic [7:0]  a, x, y, sp, fl;
  logic [15:0] pc;
  logic [7:0]  stack_mem [256];
  bit          first_item;
  out_item_t   cpu_state_q[$];

  function automatic logic [7:0] nz(logic [7:0] f, logic [7:0] v);
    nz = (f & ~(F_N | F_Z)) | (v[7] ? F_N : 8'h00) | ((v == 8'h00) ? F_Z : 8'h00);
  endfunction

  task automatic push(logic [7:0] v);
    stack_mem[sp] = v;
    sp = sp - 8'd1;
  endtask

  task automatic pull(output logic [7:0] v);
    sp = sp + 8'd1;
    v = stack_mem[sp];
  endtask

  task automatic adc(logic [7:0] m);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, a} + {1'b0, m} + {8'h00, fl[0]};
    r = sum[7:0];
    fl = sum[8] ? (fl | F_C) : (fl & ~F_C);
    fl = (((a ^ r) & (m ^ r) & 8'h80) != 0) ? (fl | F_V) : (fl & ~F_V);
    a = r;
    fl = nz(fl, r);
  endtask

  task automatic cmp(logic [7:0] r, logic [7:0] m);
    fl = (r >= m) ? (fl | F_C) : (fl & ~F_C);
    fl = nz(fl, r - m);
  endtask

  task automatic execute(in_item_t it, output out_item_t res);
    logic [7:0]  m, v, lo, hi;
    logic [15:0] w;
    logic        wr, taken;
    logic [7:0]  wdata;
    m = it.operand;
    wr = 1'b0;
    wdata = 8'h00;
    taken = 1'b0;
    if (first_item) begin
      pc = boot_pc;
      first_item = 1'b0;
    end
    pc = pc + 16'(it.length);
    case (it.kind)
      OP_ADC: adc(m);
      OP_SBC: adc(~m);
      OP_AND: begin a = a & m; fl = nz(fl, a); end
      OP_ORA: begin a = a | m; fl = nz(fl, a); end
      OP_EOR: begin a = a ^ m; fl = nz(fl, a); end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        v = it.to_memory ? m : a;
        lo = {7'd0, fl[0]};
        case (it.kind)
          OP_ASL: begin fl[0] = v[7]; v = v << 1; end
          OP_LSR: begin fl[0] = v[0]; v = v >> 1; end
          OP_ROL: begin fl[0] = v[7]; v = {v[6:0], lo[0]}; end
          default: begin fl[0] = v[0]; v = {lo[0], v[7:1]}; end
        endcase
        fl = nz(fl, v);
        if (it.to_memory) begin
          wr = 1'b1;
          wdata = v;
        end else begin
          a = v;
        end
      end
      OP_BCC: taken = !fl[0];
      OP_BCS: taken = fl[0];
      OP_BEQ: taken = fl[1];
      OP_BNE: taken = !fl[1];
      OP_BMI: taken = fl[7];
      OP_BPL: taken = !fl[7];
      OP_BVC: taken = !fl[6];
      OP_BVS: taken = fl[6];
      OP_BIT: begin
        fl = ((a & m) == 0) ? (fl | F_Z) : (fl & ~F_Z);
        fl = (fl & ~(F_N | F_V)) | (m & (F_N | F_V));
      end
      OP_BRK: begin
        pc = pc + 16'd1;
        push(pc[15:8]);
        push(pc[7:0]);
        push(fl | F_B | F_ONE);
        fl = fl | F_B | F_I;
        pc = irq_vec;
      end
      OP_CLC: fl = fl & ~F_C;
      OP_CLD: fl = fl & ~F_D;
      OP_CLI: fl = fl & ~F_I;
      OP_CLV: fl = fl & ~F_V;
      OP_SEC: fl = fl | F_C;
      OP_SED: fl = fl | F_D;
      OP_SEI: fl = fl | F_I;
      OP_CMP: cmp(a, m);
      OP_CPX: cmp(x, m);
      OP_CPY: cmp(y, m);
      OP_DEC: begin v = m - 8'd1; fl = nz(fl, v); wr = 1'b1; wdata = v; end
      OP_INC: begin v = m + 8'd1; fl = nz(fl, v); wr = 1'b1; wdata = v; end
      OP_DEX: begin x = x - 8'd1; fl = nz(fl, x); end
      OP_DEY: begin y = y - 8'd1; fl = nz(fl, y); end
      OP_INX: begin x = x + 8'd1; fl = nz(fl, x); end
      OP_INY: begin y = y + 8'd1; fl = nz(fl, y); end
      OP_JMP: pc = it.address;
      OP_JSR: begin
        w = pc - 16'd1;
        push(w[15:8]);
        push(w[7:0]);
        pc = it.address;
      end
      OP_LDA: begin a = m; fl = nz(fl, m); end
      OP_LDX: begin x = m; fl = nz(fl, m); end
      OP_LDY: begin y = m; fl = nz(fl, m); end
      OP_PHA: push(a);
      OP_PHP: push(fl | F_B | F_ONE);
      OP_PLA: begin pull(a); fl = nz(fl, a); end
      OP_PLP: begin pull(v); fl = v & ~F_ONE; end
      OP_RTI: begin
        pull(v);
        fl = v & ~F_ONE;
        pull(lo);
        pull(hi);
        pc = {hi, lo};
      end
      OP_RTS: begin
        pull(lo);
        pull(hi);
        pc = {hi, lo} + 16'd1;
      end
      OP_STA: begin wr = 1'b1; wdata = a; end
      OP_STX: begin wr = 1'b1; wdata = x; end
      OP_STY: begin wr = 1'b1; wdata = y; end
      OP_TAX: begin x = a; fl = nz(fl, x); end
      OP_TAY: begin y = a; fl = nz(fl, y); end
      OP_TSX: begin x = sp; fl = nz(fl, x); end
      OP_TXA: begin a = x; fl = nz(fl, a); end
      OP_TXS: sp = x;
      OP_TYA: begin a = y; fl = nz(fl, a); end
      default: ;
    endcase
    if (taken) pc = pc + {{8{m[7]}}, m};
    if (wr && it.address[15:8] == STACK_PAGE) stack_mem[it.address[7:0]] = wdata;
    res.acc = a;
    res.index_x = x;
    res.index_y = y;
    res.stack_ptr = sp;
    res.prog_counter = pc;
    res.status = fl | F_ONE;
    res.mem_write = wr;
    res.write_address = wr ? it.address : 16'h0000;
    res.write_data = wdata;
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t res, want;
    if (!rst_n) begin
      irq_vec = 16'h0000;
      boot_pc = 16'h0000;
      a = 8'h00;
      x = 8'h00;
      y = 8'h00;
      sp = SP_RESET;
      fl = F_I;
      first_item = 1'b1;
      cpu_state_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cpu_state_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = cpu_state_q.pop_front();
          check_field("acc", want.acc, out_data.acc);
          check_field("index_x", want.index_x, out_data.index_x);
          check_field("index_y", want.index_y, out_data.index_y);
          check_field("stack_ptr", want.stack_ptr, out_data.stack_ptr);
          check_field("prog_counter", want.prog_counter, out_data.prog_counter);
          check_field("status", want.status, out_data.status);
          check_field("mem_write", want.mem_write, out_data.mem_write);
          check_field("write_address", want.write_address, out_data.write_address);
          check_field("write_data", want.write_data, out_data.write_data);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IRQ_VECTOR) irq_vec = cfg_data;
        else boot_pc = cfg_data;
      end
      if (in_valid && !in_stall) begin
        execute(in_data, res);
        cpu_state_q.push_back(res);
      end
    end
    pending = cpu_state_q.size();
  end

endmodule

### tb/sv/tb_cpu_6502_execute_unit.sv
`timescale 1ns / 1ps

module tb_cpu_6502_execute_unit;
  import c6502_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int FIRST_SPARE_KIND = 56;
  localparam int LAST_SPARE_KIND = 63;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;
  int          fail_count;
  int          pending;
  int          sent = 0;
  int          cycles = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;
  bit          held = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cpu_6502_execute_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cpu_6502_execute_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** cpu_6502_execute_unit: FAILED **");
      $finish;
    end
  end

  // The receiver stalls in short bursts, and once for a long stretch so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && !held && sent > 700) begin
      held = 1'b1;
      stall_left = 300;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic op(logic [5:0] kind, logic [7:0] operand, logic [15:0] address = 16'h0000,
                    logic to_memory = 1'b0, logic [1:0] length = 2'd1);
    in_item_t it;
    it.kind = kind;
    it.operand = operand;
    it.address = address;
    it.to_memory = to_memory;
    it.length = length;
    send(it);
  endtask

  task automatic write_reg(logic index, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) it.kind = 6'($urandom_range(FIRST_SPARE_KIND, LAST_SPARE_KIND));
    else if (pick < 20) begin
      case ($urandom_range(0, 5))
        0: it.kind = OP_PHA;
        1: it.kind = OP_PLA;
        2: it.kind = OP_JSR;
        3: it.kind = OP_RTS;
        4: it.kind = OP_PHP;
        default: it.kind = OP_PLP;
      endcase
    end else it.kind = 6'($urandom_range(0, FIRST_SPARE_KIND - 1));
    case ($urandom_range(0, 7))
      0: it.operand = 8'h00;
      1: it.operand = 8'hFF;
      2: it.operand = 8'h80;
      3: it.operand = 8'h7F;
      default: it.operand = 8'($urandom);
    endcase
    it.address = $urandom_range(0, 1) ? 16'($urandom_range(16'h0100, 16'h01FF)) : 16'($urandom);
    it.to_memory = 1'($urandom);
    it.length = 2'($urandom);
    return it;
  endfunction

  task automatic random_run(int count);
    repeat (count) send(random_item());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(CFG_IRQ_VECTOR, 16'h0000);
    write_reg(CFG_START_PC, 16'hFFFF);

    // Fill the whole stack page once so that every later pull reads written data.
    op(OP_LDA, 8'h00, 16'h0000, 1'b0, 2'd0);
    for (int i = 0; i < 256; i++) begin
      if (i % 16 == 15) op(OP_LDA, 8'($urandom), 16'h0000, 1'b0, 2'($urandom));
      op(OP_PHA, 8'h00);
    end

    op(OP_LDA, 8'hFF);
    op(OP_ADC, 8'h01);
    op(OP_LDA, 8'h7F);
    op(OP_ADC, 8'h01);
    op(OP_SBC, 8'hFF);
    op(OP_SBC, 8'h80);
    op(OP_BIT, 8'hC0);
    op(OP_CMP, 8'h00);
    op(OP_CPX, 8'hFF);
    op(OP_JSR, 8'h00, 16'hFFFF, 1'b0, 2'd3);
    op(OP_RTS, 8'h00);
    op(OP_BRK, 8'h00);
    op(OP_RTI, 8'h00);
    op(OP_PHP, 8'h00);
    op(OP_PLP, 8'h00);
    op(OP_ASL, 8'h81, 16'h01FF, 1'b1, 2'd2);
    op(OP_ROR, 8'h01, 16'h0100, 1'b1, 2'd3);
    op(OP_DEC, 8'h00, 16'h0180, 1'b0, 2'd3);
    op(OP_STA, 8'h00, 16'h01FD, 1'b0, 2'd3);
    op(OP_PLA, 8'h00);
    op(OP_BNE, 8'h80, 16'h0000, 1'b0, 2'd2);
    op(OP_BEQ, 8'h7F, 16'h0000, 1'b0, 2'd2);
    op(6'(LAST_SPARE_KIND), 8'hFF, 16'hFFFF, 1'b1, 2'd0);
    op(OP_TXS, 8'h00, 16'h0000, 1'b0, 2'd0);
    drain();

    write_reg(CFG_IRQ_VECTOR, 16'hFFFF);
    write_reg(CFG_START_PC, 16'h0000);
    random_run(560);
    drain();

    write_reg(CFG_IRQ_VECTOR, 16'($urandom));
    write_reg(CFG_START_PC, 16'($urandom));
    random_run(560);
    drain();

    write_reg(CFG_IRQ_VECTOR, BRK_VEC);
    quiet = 1'b1;
    random_run(560);
    drain();

    if (fail_count == 0) begin
      $display("** cpu_6502_execute_unit: PASSED **");
    end else begin
      $display("** cpu_6502_execute_unit: FAILED **");
    end
    $finish;
  end

endmodule
